>>> design/ping_pong_block_reblocker_macros.svh
// Assertion macros for the ping-pong reblocker checker.
// Used by design/pprb_checker.sv; no other dependencies.
`ifndef PING_PONG_BLOCK_REBLOCKER_MACROS_SVH
`define PING_PONG_BLOCK_REBLOCKER_MACROS_SVH

// Implication checked only outside reset.
`define PPRB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pprb check failed");

// Next-cycle implication, checked only outside reset.
`define PPRB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pprb check failed");

// Next-cycle implication that also holds through reset.
`define PPRB_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pprb check failed");

`endif

>>> design/pprb_pkg.sv
// Shared constants, codes and types for the ping-pong reblocker.
// No dependencies; imported by pprb_store, pprb_checker and the top level.
package pprb_pkg;

  localparam int BLOCK_DEPTH = 4096;
  localparam int CHANNELS    = 2;

  localparam int POS_W     = $clog2(BLOCK_DEPTH);   // frame index in one buffer
  localparam int ADDR_W    = POS_W + 1;             // buffer select + frame index
  localparam int CNT_W     = 13;                    // positions and block size
  localparam int SKIP_W    = 14;
  localparam int SAMPLE_W  = 32;
  localparam int ACT_W     = 3;
  localparam int CHC_W     = 2;
  localparam int CFG_IDX_W = 1;
  localparam int IDX_W     = 12;

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE = 3'd0,
    ACT_SKIP  = 3'd1,
    ACT_READ  = 3'd2,
    ACT_POP   = 3'd3,
    ACT_CLEAR = 3'd4
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET   = 1'b0,
    CFG_CHANNELS = 1'b1
  } cfg_reg_t;

  // One access to the sample store per cycle: a frame write or a word read.
  typedef struct packed {
    logic                we0;
    logic                we1;
    logic                re;
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] wdata0;
    logic [SAMPLE_W-1:0] wdata1;
  } store_req_t;

endpackage

>>> design/pprb_store.sv
// Sample store: one synchronous memory per channel, both buffers in each.
// Depends on pprb_pkg. Zeroes every row after reset before taking requests.
module pprb_store
  import pprb_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  store_req_t          req,
  output logic                busy,
  output logic [SAMPLE_W-1:0] rdata0,
  output logic [SAMPLE_W-1:0] rdata1
);

  localparam int ROWS = 2 * BLOCK_DEPTH;

  logic [SAMPLE_W-1:0] mem0 [ROWS];
  logic [SAMPLE_W-1:0] mem1 [ROWS];

  logic [ADDR_W-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == ADDR_W'(ROWS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem0[clr_addr] <= '0;
      mem1[clr_addr] <= '0;
    end else begin
      if (req.we0) begin
        mem0[req.addr] <= req.wdata0;
      end
      if (req.we1) begin
        mem1[req.addr] <= req.wdata1;
      end
    end
  end

  // Read data holds until the next read so a stalled result keeps its word.
  always_ff @(posedge clk) begin
    if (req.re && !busy) begin
      rdata0 <= mem0[req.addr];
      rdata1 <= mem1[req.addr];
    end
  end

endmodule

>>> design/ping_pong_block_reblocker.sv
//  channel | signals                                  | transfer when
//  --------+------------------------------------------+-----------------------
//  cfg     | cfg_write cfg_index cfg_data             | cfg_write high
//  in      | in_valid/in_ready, action, samples, ...  | in_valid && in_ready
//  out     | out_valid/out_ready, read_data, flags    | out_valid && out_ready
//
// One item per cycle while in_ready is high; its result passes through the store
// read, then the output register. Positions and flags update in the cycle
// of the transfer, so every action may follow any other back to back.
// After reset the store is zeroed row by row, all 8192 rows, with in_ready low.
// Output stalls back up through one staging register into in_ready.
module ping_pong_block_reblocker
  import pprb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ACT_W-1:0]     action,
  input  logic [SAMPLE_W-1:0]  sample_ch0,
  input  logic [SAMPLE_W-1:0]  sample_ch1,
  input  logic                 source_mono,
  input  logic [SKIP_W-1:0]    skip_count,
  input  logic [IDX_W-1:0]     read_index,
  input  logic                 read_channel,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [SAMPLE_W-1:0]  read_data,
  output logic                 block_ready,
  output logic                 dropped
);

  logic [CNT_W-1:0] target_block_size;
  logic [CHC_W-1:0] channel_count;

  logic             active_buffer, active_buffer_next;
  logic [CNT_W-1:0] write_position, write_position_next;
  logic [CNT_W-1:0] spill_position, spill_position_next;
  logic             ready_flag, ready_flag_next;
  logic             drop_next;
  logic             hit_next;

  logic             s1_valid, s1_hit, s1_ch, s1_ready, s1_drop;

  logic             store_busy;
  logic [SAMPLE_W-1:0] rdata0, rdata1;
  store_req_t       req;

  logic             accept, s1_move;

  logic [CNT_W-1:0]  target;
  logic              two_ch;
  logic [CNT_W-1:0]  remaining;
  logic [SKIP_W-1:0] over;
  logic [SKIP_W:0]   spill_sum;
  logic [CNT_W-1:0]  wp_inc;
  logic [CNT_W-1:0]  wp_skip;

  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !store_busy && (!s1_valid || !out_valid || out_ready);
  assign accept   = in_valid && in_ready;

  // Registers are used clamped to their legal ranges.
  always_comb begin
    if (target_block_size == '0) begin
      target = CNT_W'(1);
    end else if (target_block_size > CNT_W'(BLOCK_DEPTH)) begin
      target = CNT_W'(BLOCK_DEPTH);
    end else begin
      target = target_block_size;
    end
  end
  assign two_ch = (channel_count >= CHC_W'(CHANNELS));

  assign remaining = (target > write_position) ? target - write_position : '0;
  assign wp_inc    = write_position + CNT_W'(1);
  assign wp_skip   = write_position + CNT_W'(skip_count);
  assign over      = skip_count - SKIP_W'(remaining);
  assign spill_sum = (SKIP_W + 1)'(spill_position) + (SKIP_W + 1)'(over);

  always_comb begin
    active_buffer_next  = active_buffer;
    write_position_next = write_position;
    spill_position_next = spill_position;
    ready_flag_next     = ready_flag;
    drop_next           = 1'b0;
    hit_next            = 1'b0;
    req.we0    = 1'b0;
    req.we1    = 1'b0;
    req.re     = 1'b0;
    req.addr   = {active_buffer, write_position[POS_W-1:0]};
    req.wdata0 = sample_ch0;
    req.wdata1 = source_mono ? sample_ch0 : sample_ch1;
    case (action)
      ACT_WRITE: begin
        if (remaining != '0) begin
          req.we0             = accept;
          req.we1             = accept && two_ch;
          write_position_next = wp_inc;
          if (wp_inc == target) begin
            ready_flag_next = 1'b1;
          end
        end else begin
          ready_flag_next = 1'b1;
          if (spill_position >= target) begin
            drop_next = 1'b1;
          end else begin
            req.addr            = {~active_buffer, spill_position[POS_W-1:0]};
            req.we0             = accept;
            req.we1             = accept && two_ch;
            spill_position_next = spill_position + CNT_W'(1);
          end
        end
      end
      ACT_SKIP: begin
        if (skip_count <= SKIP_W'(remaining)) begin
          write_position_next = wp_skip;
          if (wp_skip == target) begin
            ready_flag_next = 1'b1;
          end
        end else begin
          ready_flag_next = 1'b1;
          if (spill_sum > (SKIP_W + 1)'(target)) begin
            spill_position_next = target;
            drop_next           = 1'b1;
          end else begin
            spill_position_next = spill_sum[CNT_W-1:0];
          end
        end
      end
      ACT_READ: begin
        req.addr = {active_buffer, read_index};
        req.re   = accept;
        hit_next = (CNT_W'(read_index) < target) && (!read_channel || two_ch);
      end
      ACT_POP: begin
        if (!ready_flag) begin
          drop_next = 1'b1;
        end else begin
          active_buffer_next  = ~active_buffer;
          write_position_next = spill_position;
          spill_position_next = '0;
          ready_flag_next     = (spill_position == target);
        end
      end
      ACT_CLEAR: begin
        active_buffer_next  = 1'b0;
        write_position_next = '0;
        spill_position_next = '0;
        ready_flag_next     = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_block_size <= CNT_W'(BLOCK_DEPTH);
      channel_count     <= CHC_W'(CHANNELS);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TARGET:   target_block_size <= cfg_data;
        CFG_CHANNELS: channel_count     <= cfg_data[CHC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_buffer  <= 1'b0;
      write_position <= '0;
      spill_position <= '0;
      ready_flag     <= 1'b0;
    end else if (accept) begin
      active_buffer  <= active_buffer_next;
      write_position <= write_position_next;
      spill_position <= spill_position_next;
      ready_flag     <= ready_flag_next;
    end
  end

  // Stage 1 waits for the store read; then the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit   <= hit_next;
      s1_ch    <= read_channel;
      s1_ready <= ready_flag_next;
      s1_drop  <= drop_next;
    end
    if (s1_move) begin
      read_data   <= s1_hit ? (s1_ch ? rdata1 : rdata0) : '0;
      block_ready <= s1_ready;
      dropped     <= s1_drop;
    end
  end

  pprb_store u_store (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .busy   (store_busy),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

endmodule

>>> design/pprb_checker.sv
// Port-level checks for the ping-pong reblocker, bound to the top level.
// Depends on pprb_pkg and ping_pong_block_reblocker_macros.svh.
`include "ping_pong_block_reblocker_macros.svh"

module pprb_checker
  import pprb_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [SAMPLE_W-1:0]  read_data,
  input logic                 block_ready,
  input logic                 dropped
);

  // Store clearing must hold off input right after reset.
  `PPRB_ASSERT_RST(a_clear_holds_input, rst, !in_ready)

  // Only reads return data, and reads never drop.
  `PPRB_ASSERT_IMP(a_drop_no_data, out_valid && dropped, read_data == '0)

  // A stalled result keeps its value.
  `PPRB_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(read_data) && $stable(block_ready) && $stable(dropped))

  // A new result follows an input transfer through stage 1 and the output register.
  `PPRB_ASSERT_IMP(a_out_latency, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind ping_pong_block_reblocker pprb_checker u_pprb_checker (.*);
